// ===== sv/assert_macros.svh =====
// assertion macros shared by the cursor position and clip rtl
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ON(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_ON(lbl, clk, rstn, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/hcpc_pkg.sv =====
// shared types and constants for the cursor position and clip block
// no dependencies
package hcpc_pkg;

    localparam int CURSOR_DIM_BITS = 8;
    localparam int CUR_LANES_W     = 4 * CURSOR_DIM_BITS;
    localparam int POS_W           = 17;
    localparam int HALF_W          = 16;
    localparam int SRC_W           = 8;
    localparam int CALC_W          = 19;
    localparam int REG_W           = 32;
    localparam int CFG_IDX_W       = 3;
    localparam int S_TDATA_W       = 40;
    localparam int M_TDATA_W       = 104;
    localparam int M_TUSER_W       = 3;

    localparam logic [POS_W-1:0]   FOLD_STEP  = 17'h10000;
    localparam logic [POS_W:0]     FOLD_LIMIT = 18'h08000;
    localparam logic [POS_W-1:0]   LAST_RESET = 17'h18001;

    localparam logic [CFG_IDX_W-1:0] REG_GAME_ACTIVE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOWED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_VER  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_SIZE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEF_CURSOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GAME_CURSOR = 3'd6;

    typedef struct packed {
        logic             game_active;
        logic             windowed;
        logic [REG_W-1:0] window_horizontal;
        logic [REG_W-1:0] window_vertical;
        logic [REG_W-1:0] area_size;
        logic [REG_W-1:0] default_cursor;
        logic [REG_W-1:0] game_cursor;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] last_x;
        logic [POS_W-1:0] last_y;
        logic             last_use_game;
    } last_t;

    typedef struct packed {
        logic             moved;
        logic             on_screen;
        logic             use_game;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] dest_left;
        logic [POS_W-1:0] dest_top;
        logic [POS_W-1:0] dest_right;
        logic [POS_W-1:0] dest_bottom;
        logic [SRC_W-1:0] src_left;
        logic [SRC_W-1:0] src_top;
        logic [SRC_W-1:0] src_right;
        logic [SRC_W-1:0] src_bottom;
    } res_t;

endpackage

// ===== sv/hcpc_cfg.sv =====
// configuration register file for the cursor position and clip block
// depends on hcpc_pkg
module hcpc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcpc_pkg::REG_W-1:0]      cfg_data,
    output hcpc_pkg::cfg_t                  cfg
);
    import hcpc_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_GAME_ACTIVE: cfg_reg.game_active       <= cfg_data[0];
                REG_WINDOWED:    cfg_reg.windowed          <= cfg_data[0];
                REG_WINDOW_HOR:  cfg_reg.window_horizontal <= cfg_data;
                REG_WINDOW_VER:  cfg_reg.window_vertical   <= cfg_data;
                REG_AREA_SIZE:   cfg_reg.area_size         <= cfg_data;
                REG_DEF_CURSOR:  cfg_reg.default_cursor    <= cfg_data;
                REG_GAME_CURSOR: cfg_reg.game_cursor       <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/hcpc_calc.sv =====
// fold, cursor choice, change test and rectangle clipping for one sample
// depends on hcpc_pkg
module hcpc_calc (
    input  hcpc_pkg::cfg_t                 cfg,
    input  hcpc_pkg::last_t                last,
    input  logic [hcpc_pkg::POS_W-1:0]     pos_x,
    input  logic [hcpc_pkg::POS_W-1:0]     pos_y,
    input  logic                           save_valid,
    output hcpc_pkg::res_t                 res
);
    import hcpc_pkg::*;

    logic [POS_W-1:0]            fx, fy;
    logic signed [POS_W:0]       x18, y18;
    logic signed [POS_W:0]       win_l, win_r, win_t, win_b;
    logic                        use_game, moved, on;
    logic [REG_W-1:0]            cur;
    logic [CUR_LANES_W+REG_W-1:0] cur_wide;
    logic [CUR_LANES_W-1:0]      cur_ext;
    logic [CURSOR_DIM_BITS-1:0]  w, h, hx, hy;
    logic signed [CALC_W-1:0]    xs, ys, ws, hs, hxs, hys, aw, ah;
    logic signed [CALC_W-1:0]    dl, dt, dr, db, sl, st, sr, sb;

    always_comb begin
        fx = pos_x;
        fy = pos_y;
        if (cfg.windowed && $signed({pos_x[POS_W-1], pos_x}) > $signed(FOLD_LIMIT)) begin
            fx = pos_x - FOLD_STEP;
        end
        if (cfg.windowed && $signed({pos_y[POS_W-1], pos_y}) > $signed(FOLD_LIMIT)) begin
            fy = pos_y - FOLD_STEP;
        end

        x18   = $signed({fx[POS_W-1], fx});
        y18   = $signed({fy[POS_W-1], fy});
        win_l = $signed({2'b00, cfg.window_horizontal[HALF_W-1:0]});
        win_r = $signed({2'b00, cfg.window_horizontal[REG_W-1:HALF_W]});
        win_t = $signed({2'b00, cfg.window_vertical[HALF_W-1:0]});
        win_b = $signed({2'b00, cfg.window_vertical[REG_W-1:HALF_W]});

        use_game = cfg.game_active && x18 >= win_l && x18 < win_r
                   && y18 >= win_t && y18 < win_b;
        moved = !(save_valid && fx == last.last_x && fy == last.last_y
                  && use_game == last.last_use_game);

        cur      = use_game ? cfg.game_cursor : cfg.default_cursor;
        cur_wide = {{CUR_LANES_W{1'b0}}, cur};
        cur_ext  = cur_wide[CUR_LANES_W-1:0];
        w  = cur_ext[0*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        h  = cur_ext[1*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        hx = cur_ext[2*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        hy = cur_ext[3*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];

        xs  = $signed({{(CALC_W-POS_W){fx[POS_W-1]}}, fx});
        ys  = $signed({{(CALC_W-POS_W){fy[POS_W-1]}}, fy});
        ws  = $signed({{(CALC_W-CURSOR_DIM_BITS){1'b0}}, w});
        hs  = $signed({{(CALC_W-CURSOR_DIM_BITS){1'b0}}, h});
        hxs = $signed({{(CALC_W-CURSOR_DIM_BITS){1'b0}}, hx});
        hys = $signed({{(CALC_W-CURSOR_DIM_BITS){1'b0}}, hy});
        aw  = $signed({{(CALC_W-HALF_W){1'b0}}, cfg.area_size[HALF_W-1:0]});
        ah  = $signed({{(CALC_W-HALF_W){1'b0}}, cfg.area_size[REG_W-1:HALF_W]});

        dl = xs - hxs;
        dt = ys - hys;
        dr = xs + (ws - hxs);
        db = ys + (hs - hys);
        sl = '0;
        st = '0;
        sr = ws;
        sb = hs;

        on = dr >= 0 && db >= 0 && dl <= aw && dt <= ah;
        if (on) begin
            if (dl < 0) begin
                sl = -dl;
                dl = '0;
            end
            if (dr > aw) begin
                sr = ws - (dr - aw);
                dr = aw;
            end
            if (dt < 0) begin
                st = -dt;
                dt = '0;
            end
            if (db > ah) begin
                sb = hs - (db - ah);
                db = ah;
            end
        end

        res = '0;
        res.use_game = use_game;
        res.pos_x    = fx;
        res.pos_y    = fy;
        if (moved) begin
            res.moved       = 1'b1;
            res.on_screen   = on;
            res.dest_left   = dl[POS_W-1:0];
            res.dest_top    = dt[POS_W-1:0];
            res.dest_right  = dr[POS_W-1:0];
            res.dest_bottom = db[POS_W-1:0];
            res.src_left    = sl[SRC_W-1:0];
            res.src_top     = st[SRC_W-1:0];
            res.src_right   = sr[SRC_W-1:0];
            res.src_bottom  = sb[SRC_W-1:0];
        end
    end

endmodule

// ===== sv/hardware_cursor_position_clip.sv =====
// cursor position and clip block, top level: input register, calc, result register
// a word waits in the input register until the result register is free or being read, then moves there
// throughput: one word per cycle while m_tready holds, set by the single input and result register pair
// when a moved word goes to the result register the last position updates, and the cursor choice if on screen
// reset (aresetn low, synchronous) clears both valid flags and config, sets last position to LAST_RESET
// depends on hcpc_pkg, hcpc_cfg, hcpc_calc and assert_macros.svh
`include "assert_macros.svh"
module hardware_cursor_position_clip (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hcpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hcpc_pkg::REG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x, pos_y, zero fill
    input  logic [hcpc_pkg::S_TDATA_W-1:0]  s_tdata,
    // save_valid
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // dest_left, dest_top, dest_right, dest_bottom, src_left, src_top,
    // src_right, src_bottom, zero fill
    output logic [hcpc_pkg::M_TDATA_W-1:0]  m_tdata,
    // moved, on_screen, use_game
    output logic [hcpc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import hcpc_pkg::*;

    cfg_t              cfg;
    last_t             last;
    res_t              res;
    logic              in_valid_reg;
    logic [POS_W-1:0]  in_x_reg, in_y_reg;
    logic              in_sv_reg;
    logic              out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [M_TUSER_W-1:0] out_user_reg;
    logic [POS_W-1:0]  last_x_reg, last_y_reg;
    logic              last_game_reg;
    logic              advance;

    hcpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign last.last_x        = last_x_reg;
    assign last.last_y        = last_y_reg;
    assign last.last_use_game = last_game_reg;

    hcpc_calc u_calc (
        .cfg        (cfg),
        .last       (last),
        .pos_x      (in_x_reg),
        .pos_y      (in_y_reg),
        .save_valid (in_sv_reg),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_x_reg    <= LAST_RESET;
            last_y_reg    <= LAST_RESET;
            last_game_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && res.moved) begin
                last_x_reg <= res.pos_x;
                last_y_reg <= res.pos_y;
                if (res.on_screen) begin
                    last_game_reg <= res.use_game;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_x_reg  <= s_tdata[POS_W-1:0];
            in_y_reg  <= s_tdata[2*POS_W-1:POS_W];
            in_sv_reg <= s_tuser;
        end
        if (advance) begin
            out_data_reg <= {4'b0000, res.src_bottom, res.src_right, res.src_top,
                             res.src_left, res.dest_bottom, res.dest_right,
                             res.dest_top, res.dest_left};
            out_user_reg <= {res.use_game, res.on_screen, res.moved};
        end
    end

    `ASSERT_ON(a_idle_zero, aclk, aresetn, m_tvalid && !m_tuser[0] |-> m_tdata == '0 && !m_tuser[1], "unchanged word carries rectangle data")
    `ASSERT_ON(a_on_moved, aclk, aresetn, m_tvalid && m_tuser[1] |-> m_tuser[0], "on screen without move")
    `ASSERT_ON(a_adv_out, aclk, aresetn, advance |=> m_tvalid, "advanced word not presented")
    `ASSERT_ON(a_state_hold, aclk, aresetn, advance && !res.moved |=> $stable(last_x_reg) && $stable(last_y_reg) && $stable(last_game_reg), "state changed without move")
    `ASSERT_ALWAYS(a_reset_clear, aclk, !aresetn |=> !m_tvalid && !in_valid_reg, "reset left a word pending")

endmodule

// ===== tb/sv/cursor_clip_checker.sv =====
// checker for the cursor position and clip block: follows the register, input and result
// channels, predicts every result word and compares it field by field; depends on hcpc_pkg
module cursor_clip_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [hcpc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hcpc_pkg::REG_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hcpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hcpc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [hcpc_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             error_count,
    output int                             pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import hcpc_pkg::*;

    localparam int SRC_BASE    = 4 * POS_W;
    localparam int LAST_START  = int'($signed(LAST_RESET));
    localparam int MAX_PRINTED = 200;

    typedef struct packed {
        logic             moved;
        logic             on_screen;
        logic             use_game;
        logic [POS_W-1:0] dest_left;
        logic [POS_W-1:0] dest_top;
        logic [POS_W-1:0] dest_right;
        logic [POS_W-1:0] dest_bottom;
        logic [SRC_W-1:0] src_left;
        logic [SRC_W-1:0] src_top;
        logic [SRC_W-1:0] src_right;
        logic [SRC_W-1:0] src_bottom;
    } clip_word_t;

    cfg_t       regs_shadow = '0;
    int         last_x = LAST_START;
    int         last_y = LAST_START;
    logic       last_game = 1'b0;
    clip_word_t expected_clips[$];
    int         mismatches = 0;
    int         results_checked = 0;

    assign error_count = mismatches;

    task automatic report_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("ERROR: %s", msg);
    endtask

    task automatic compare_field(input string name, input logic [POS_W-1:0] got, want);
        if (got !== want)
            report_error($sformatf("word %0d %s: got 0x%0h, expected 0x%0h",
                                   results_checked, name, got, want));
    endtask

    function automatic clip_word_t predict_cursor_clip(input logic [POS_W-1:0] raw_x, raw_y,
                                                        input logic save);
        clip_word_t       res;
        logic [REG_W-1:0] cur;
        logic             game;
        int x, y, w, h, hx, hy, dl, dt, dr, db, sl, st, sr, sb, aw, ah;
        x = $signed(raw_x);
        y = $signed(raw_y);
        if (regs_shadow.windowed) begin
            if (x > int'(FOLD_LIMIT)) x -= int'(FOLD_STEP);
            if (y > int'(FOLD_LIMIT)) y -= int'(FOLD_STEP);
        end
        game = regs_shadow.game_active
            && x >= int'(regs_shadow.window_horizontal[HALF_W-1:0])
            && x <  int'(regs_shadow.window_horizontal[REG_W-1:HALF_W])
            && y >= int'(regs_shadow.window_vertical[HALF_W-1:0])
            && y <  int'(regs_shadow.window_vertical[REG_W-1:HALF_W]);
        res = '0;
        res.use_game = game;
        if (save && x == last_x && y == last_y && game == last_game)
            return res;
        last_x = x;
        last_y = y;
        cur = game ? regs_shadow.game_cursor : regs_shadow.default_cursor;
        w  = cur[0*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        h  = cur[1*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        hx = cur[2*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        hy = cur[3*CURSOR_DIM_BITS +: CURSOR_DIM_BITS];
        dl = x - hx;
        dt = y - hy;
        dr = x + (w - hx);
        db = y + (h - hy);
        sl = 0;
        st = 0;
        sr = w;
        sb = h;
        aw = regs_shadow.area_size[HALF_W-1:0];
        ah = regs_shadow.area_size[REG_W-1:HALF_W];
        res.moved = 1'b1;
        if (dr >= 0 && db >= 0 && dl <= aw && dt <= ah) begin
            if (dl < 0) begin
                sl = -dl;
                dl = 0;
            end
            if (dr > aw) begin
                sr -= dr - aw;
                dr = aw;
            end
            if (dt < 0) begin
                st = -dt;
                dt = 0;
            end
            if (db > ah) begin
                sb -= db - ah;
                db = ah;
            end
            res.on_screen = 1'b1;
            last_game = game;
        end
        res.dest_left   = dl[POS_W-1:0];
        res.dest_top    = dt[POS_W-1:0];
        res.dest_right  = dr[POS_W-1:0];
        res.dest_bottom = db[POS_W-1:0];
        res.src_left    = sl[SRC_W-1:0];
        res.src_top     = st[SRC_W-1:0];
        res.src_right   = sr[SRC_W-1:0];
        res.src_bottom  = sb[SRC_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        clip_word_t seen;
        clip_word_t want;
        if (!aresetn) begin
            regs_shadow = '0;
            last_x = LAST_START;
            last_y = LAST_START;
            last_game = 1'b0;
            expected_clips.delete();
        end else begin
            // results first: a word accepted at this edge cannot leave at the same edge
            if (m_tvalid && m_tready) begin
                results_checked++;
                seen.moved       = m_tuser[0];
                seen.on_screen   = m_tuser[1];
                seen.use_game    = m_tuser[2];
                seen.dest_left   = m_tdata[0*POS_W +: POS_W];
                seen.dest_top    = m_tdata[1*POS_W +: POS_W];
                seen.dest_right  = m_tdata[2*POS_W +: POS_W];
                seen.dest_bottom = m_tdata[3*POS_W +: POS_W];
                seen.src_left    = m_tdata[SRC_BASE + 0*SRC_W +: SRC_W];
                seen.src_top     = m_tdata[SRC_BASE + 1*SRC_W +: SRC_W];
                seen.src_right   = m_tdata[SRC_BASE + 2*SRC_W +: SRC_W];
                seen.src_bottom  = m_tdata[SRC_BASE + 3*SRC_W +: SRC_W];
                if (expected_clips.size() == 0) begin
                    report_error($sformatf("word %0d arrived with nothing expected",
                                           results_checked));
                end else begin
                    want = expected_clips.pop_front();
                    compare_field("moved", seen.moved, want.moved);
                    compare_field("on_screen", seen.on_screen, want.on_screen);
                    compare_field("use_game", seen.use_game, want.use_game);
                    compare_field("dest_left", seen.dest_left, want.dest_left);
                    compare_field("dest_top", seen.dest_top, want.dest_top);
                    compare_field("dest_right", seen.dest_right, want.dest_right);
                    compare_field("dest_bottom", seen.dest_bottom, want.dest_bottom);
                    compare_field("src_left", seen.src_left, want.src_left);
                    compare_field("src_top", seen.src_top, want.src_top);
                    compare_field("src_right", seen.src_right, want.src_right);
                    compare_field("src_bottom", seen.src_bottom, want.src_bottom);
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAME_ACTIVE: regs_shadow.game_active       = cfg_data[0];
                    REG_WINDOWED:    regs_shadow.windowed          = cfg_data[0];
                    REG_WINDOW_HOR:  regs_shadow.window_horizontal = cfg_data;
                    REG_WINDOW_VER:  regs_shadow.window_vertical   = cfg_data;
                    REG_AREA_SIZE:   regs_shadow.area_size         = cfg_data;
                    REG_DEF_CURSOR:  regs_shadow.default_cursor    = cfg_data;
                    REG_GAME_CURSOR: regs_shadow.game_cursor       = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_clips.push_back(predict_cursor_clip(s_tdata[0 +: POS_W],
                                                             s_tdata[POS_W +: POS_W],
                                                             s_tuser));
        end
        pending_count <= expected_clips.size();
    end

endmodule

// ===== tb/sv/tb_hardware_cursor_position_clip.sv =====
// testbench top for the cursor position and clip block: clock, reset, register writes,
// pointer sample stimulus and result back-pressure; depends on hcpc_pkg and cursor_clip_checker
module tb_hardware_cursor_position_clip;
    timeunit 1ns;
    timeprecision 1ps;

    import hcpc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNKNOWN = 3'd7;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 75;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int               errors;
    int               pending;
    int               idle_cycles    = 0;
    int               scr_w          = 0;
    int               scr_h          = 0;
    bit               sender_idles   = 1'b1;
    bit               receiver_idles = 1'b1;
    bit               hold_req       = 1'b0;
    logic [POS_W-1:0] prev_x         = '0;
    logic [POS_W-1:0] prev_y         = '0;

    hardware_cursor_position_clip u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    cursor_clip_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .error_count   (errors),
        .pending_count (pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [REG_W-1:0] pack_cursor(input int w, h, hx, hy);
        return {CURSOR_DIM_BITS'(hy), CURSOR_DIM_BITS'(hx),
                CURSOR_DIM_BITS'(h), CURSOR_DIM_BITS'(w)};
    endfunction

    function automatic logic [REG_W-1:0] random_cursor();
        int w;
        int h;
        if ($urandom_range(0, 9) < 3) return $urandom();
        w = $urandom_range(1, 64);
        h = $urandom_range(1, 64);
        return pack_cursor(w, h, $urandom_range(0, w), $urandom_range(0, h));
    endfunction

    // mostly around the screen, some near the fold point, the rest anywhere
    function automatic logic [POS_W-1:0] pick_coord(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return POS_W'(int'($urandom_range(0, span + 400)) - 200);
        if (r < 80) return POS_W'($urandom_range(32700, 32840));
        return POS_W'($urandom());
    endfunction

    // receiver: random stalls, or one long hold-off on request
    initial begin
        int gap;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                gap = receiver_idles ? pick_gap() : 0;
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_tready <= 1'b1;
            end
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic program_all(input logic ga, wd,
                               input logic [REG_W-1:0] wh, wv, area, dcur, gcur);
        cfg_write(REG_UNKNOWN, $urandom());
        cfg_write(REG_GAME_ACTIVE, {31'($urandom()), ga});
        cfg_write(REG_WINDOWED, {31'($urandom()), wd});
        cfg_write(REG_WINDOW_HOR, wh);
        cfg_write(REG_WINDOW_VER, wv);
        cfg_write(REG_AREA_SIZE, area);
        cfg_write(REG_DEF_CURSOR, dcur);
        cfg_write(REG_GAME_CURSOR, gcur);
        cfg_valid <= 1'b0;
        scr_w = area[HALF_W-1:0];
        scr_h = area[REG_W-1:HALF_W];
    endtask

    task automatic send_word(input logic [POS_W-1:0] px, py, input logic save);
        int gap;
        gap = sender_idles ? pick_gap() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 2*POS_W){1'b0}}, py, px};
        s_tuser  <= save;
        do @(posedge aclk); while (!s_tready);
        prev_x = px;
        prev_y = py;
    endtask

    // block is idle once every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        logic [REG_W-1:0] area;
        logic [REG_W-1:0] wh;
        logic [REG_W-1:0] wv;
        int               lo;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // game window 100..400 x 50..300 on a 640x480 screen, fold on
        program_all(1'b1, 1'b1, {16'd400, 16'd100}, {16'd300, 16'd50}, {16'd480, 16'd640},
                    pack_cursor(32, 32, 4, 6), pack_cursor(16, 24, 8, 12));
        send_word(0, 0, 1'b0);
        send_word(200, 100, 1'b0);
        send_word(200, 100, 1'b1);
        send_word(200, 100, 1'b0);
        send_word(99, 100, 1'b1);
        send_word(100, 50, 1'b0);
        send_word(399, 299, 1'b1);
        send_word(400, 300, 1'b0);
        send_word(639, 479, 1'b0);
        send_word(644, 486, 1'b0);
        send_word(645, 487, 1'b0);
        send_word(-28, -26, 1'b0);
        send_word(-29, -27, 1'b0);
        send_word(-29, -27, 1'b1);
        send_word(17'h0ffff, 17'h08001, 1'b0);
        send_word(17'h08000, 17'h08000, 1'b0);
        send_word(17'h10000, 17'h10000, 1'b0);
        drain();

        // everything at its maximum, no fold
        program_all(1'b0, 1'b0, '1, '1, '1, '1, '1);
        send_word(17'h0ffff, 17'h0ffff, 1'b0);
        send_word(17'h10000, 17'h10000, 1'b1);
        send_word(0, 0, 1'b1);
        drain();

        // empty screen and window, hotspot beyond the cursor size
        program_all(1'b1, 1'b1, '0, '0, '0,
                    pack_cursor(10, 12, 200, 250), pack_cursor(10, 12, 200, 250));
        send_word(0, 0, 1'b0);
        send_word(300, 300, 1'b0);
        drain();

        // game window spans 0 up to but not including 0xffff on both axes
        program_all(1'b1, 1'b0, {16'hffff, 16'h0}, {16'hffff, 16'h0}, {16'd480, 16'd640},
                    pack_cursor(8, 8, 0, 0), pack_cursor(20, 20, 100, 100));
        send_word(150, 150, 1'b0);
        send_word(150, 150, 1'b1);
        send_word(-5, 3, 1'b1);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sender_idles   = (p != 2) && (p != 4);
            receiver_idles = (p != 2) && (p != 6);
            if ($urandom_range(0, 4) == 0)
                area = $urandom();
            else
                area = {16'($urandom_range(64, 800)), 16'($urandom_range(64, 1024))};
            if ($urandom_range(0, 4) == 0) begin
                wh = $urandom();
                wv = $urandom();
            end else begin
                lo = $urandom_range(0, area[HALF_W-1:0]);
                wh = {16'(lo + $urandom_range(0, 600)), 16'(lo)};
                lo = $urandom_range(0, area[REG_W-1:HALF_W]);
                wv = {16'(lo + $urandom_range(0, 600)), 16'(lo)};
            end
            program_all($urandom_range(0, 1), $urandom_range(0, 1), wh, wv, area,
                        random_cursor(), random_cursor());
            if (p == 4)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if ($urandom_range(0, 99) < 30)
                    send_word(prev_x, prev_y, $urandom_range(0, 4) != 0);
                else
                    send_word(pick_coord(scr_w), pick_coord(scr_h), $urandom_range(0, 1));
            end
            drain();
        end

        if (errors == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/hcpc_pkg.sv
sv/hcpc_cfg.sv
sv/hcpc_calc.sv
sv/hardware_cursor_position_clip.sv
tb/sv/cursor_clip_checker.sv
tb/sv/tb_hardware_cursor_position_clip.sv
